FILE: design/gsc_pkg.sv
// ----------------------------------------------------------------------------
// gsc_pkg
// Shared constants and types for the greedy set cover engine.
// ----------------------------------------------------------------------------
package gsc_pkg;

    localparam int DEF_MAX_EXAMPLES   = 64;
    localparam int DEF_MAX_HYPOTHESES = 64;

    // Hypothesis bits counted by one cell of the popcount chain.
    localparam int CELL_BITS = 8;

    localparam int CFG_DATA_W = 7;
    localparam int EX_IDX_W   = 6;
    localparam int MASK_W     = 64;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    localparam logic REG_EXAMPLE_COUNT    = 1'b0;
    localparam logic REG_HYPOTHESIS_COUNT = 1'b1;

    localparam logic STATUS_OK          = 1'b0;
    localparam logic STATUS_UNCOVERABLE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

endpackage

FILE: design/gsc_if.sv
// ----------------------------------------------------------------------------
// gsc_if
// Handshake channels of the greedy set cover engine.
// ----------------------------------------------------------------------------
interface gsc_in_if
    import gsc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                kind;
    logic [EX_IDX_W-1:0] example_index;
    logic [MASK_W-1:0]   cover_mask;

    modport source (output valid, kind, example_index, cover_mask, input ready);
    modport sink   (input valid, kind, example_index, cover_mask, output ready);
endinterface

interface gsc_out_if
    import gsc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [EX_IDX_W-1:0] chosen_example;
    logic                last_pick;
    logic                status;

    modport source (output valid, chosen_example, last_pick, status, input ready);
    modport sink   (input valid, chosen_example, last_pick, status, output ready);
endinterface

interface gsc_cfg_if
    import gsc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/gsc_cell.sv
// ----------------------------------------------------------------------------
// gsc_cell
// One cell of the popcount chain: adds the set bits of its slice and passes
// the row, its index and the running sum to the next cell.
// ----------------------------------------------------------------------------
module gsc_cell
    import gsc_pkg::*;
#(
    parameter int H     = DEF_MAX_HYPOTHESES,
    parameter int IW    = 6,
    parameter int SW    = 7,
    parameter int SLICE = 0
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          valid_in,
    input  logic [IW-1:0] idx_in,
    input  logic [SW-1:0] sum_in,
    input  logic [H-1:0]  bits_in,
    output logic          valid_out,
    output logic [IW-1:0] idx_out,
    output logic [SW-1:0] sum_out,
    output logic [H-1:0]  bits_out
);

    logic          valid_reg;
    logic [IW-1:0] idx_reg;
    logic [SW-1:0] sum_reg;
    logic [H-1:0]  bits_reg;
    logic [SW-1:0] sum_next;

    always_comb
    begin
        sum_next = sum_in;
        for (int b = 0; b < CELL_BITS; b++)
        begin
            if (SLICE * CELL_BITS + b < H)
            begin
                sum_next = sum_next + SW'(bits_in[SLICE * CELL_BITS + b]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_in;
        sum_reg  <= sum_next;
        bits_reg <= bits_in;
    end

    assign valid_out = valid_reg;
    assign idx_out   = idx_reg;
    assign sum_out   = sum_reg;
    assign bits_out  = bits_reg;

endmodule

FILE: design/greedy_set_cover.sv
// Each greedy step scans the used rows one per cycle out of the row memory;
// each row then passes the row read, the bit stage and the popcount cells
// before the best-gain selection. A run of n picks takes n such steps.
// Row loads are taken one per cycle while no run is in progress.
// Reset clears the control state and sets both counts to 64; rows are
// undefined until written.
// ----------------------------------------------------------------------------
// greedy_set_cover
// Row memory, scan sequencer, popcount cell chain and best-gain selection.
// ----------------------------------------------------------------------------
module greedy_set_cover
    import gsc_pkg::*;
#(
    parameter int MAX_EXAMPLES   = DEF_MAX_EXAMPLES,
    parameter int MAX_HYPOTHESES = DEF_MAX_HYPOTHESES
)(
    input logic       clk,
    input logic       rst_n,
    gsc_in_if.sink    in_ch,
    gsc_out_if.source out_ch,
    gsc_cfg_if.sink   cfg_ch
);

    localparam int H     = MAX_HYPOTHESES;
    localparam int IW    = $clog2(MAX_EXAMPLES);
    localparam int UW    = $clog2(MAX_EXAMPLES + 1);
    localparam int SW    = $clog2(H + 1);
    localparam int NCELL = (H + CELL_BITS - 1) / CELL_BITS;
    localparam int DW    = $clog2(NCELL + 3);
    localparam int CMPW  = (UW > CFG_DATA_W) ? UW : CFG_DATA_W;
    localparam int HCW   = (SW > CFG_DATA_W) ? SW : CFG_DATA_W;

    state_t state_reg;
    logic [CFG_DATA_W-1:0] example_count_reg;
    logic [CFG_DATA_W-1:0] hypothesis_count_reg;
    logic [UW-1:0]  used_reg;
    logic [H-1:0]   hmask_reg;
    logic [H-1:0]   covered_reg;
    logic           first_reg;
    logic [IW-1:0]  scan_idx_reg;
    logic [DW-1:0]  drain_reg;
    logic [SW-1:0]  best_gain_reg;
    logic [IW-1:0]  best_idx_reg;
    logic [H-1:0]   best_bits_reg;

    logic [H-1:0]   rows [MAX_EXAMPLES];
    logic           rd_valid_reg;
    logic [IW-1:0]  rd_idx_reg;
    logic [H-1:0]   rd_data_reg;
    logic           s1_valid_reg;
    logic [IW-1:0]  s1_idx_reg;
    logic [H-1:0]   s1_bits_reg;

    logic           out_valid_reg;
    logic [EX_IDX_W-1:0] out_example_reg;
    logic           out_last_reg;
    logic           out_status_reg;

    logic           cv [NCELL+1];
    logic [IW-1:0]  ci [NCELL+1];
    logic [SW-1:0]  cs [NCELL+1];
    logic [H-1:0]   cb [NCELL+1];

    logic in_fire;
    logic out_free;
    logic [HCW-1:0] hc;
    logic [CMPW-1:0] used_c;
    logic [H-1:0]   hmask_c;
    logic [H-1:0]   new_cov;

    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = 1'b1;
    assign out_free     = !out_valid_reg || out_ch.ready;
    assign new_cov      = covered_reg | best_bits_reg;

    always_comb
    begin
        if (hypothesis_count_reg == '0)
        begin
            hc = HCW'(1);
        end
        else if (HCW'(hypothesis_count_reg) > HCW'(H))
        begin
            hc = HCW'(H);
        end
        else
        begin
            hc = HCW'(hypothesis_count_reg);
        end
        if (example_count_reg == '0)
        begin
            used_c = CMPW'(1);
        end
        else if (CMPW'(example_count_reg) > CMPW'(MAX_EXAMPLES))
        begin
            used_c = CMPW'(MAX_EXAMPLES);
        end
        else
        begin
            used_c = CMPW'(example_count_reg);
        end
        for (int h = 0; h < H; h++)
        begin
            hmask_c[h] = (HCW'(h) < hc);
        end
    end

    // Row memory: loads write, the scan reads one row per cycle.
    always_ff @(posedge clk)
    begin
        if (in_fire && in_ch.kind == KIND_LOAD
            && 32'(in_ch.example_index) < MAX_EXAMPLES)
        begin
            rows[IW'(in_ch.example_index)] <= in_ch.cover_mask[H-1:0];
        end
        rd_data_reg <= rows[scan_idx_reg];
        rd_idx_reg  <= scan_idx_reg;
        s1_idx_reg  <= rd_idx_reg;
        s1_bits_reg <= rd_data_reg & hmask_reg & ~covered_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= (state_reg == ST_SCAN);
            s1_valid_reg <= rd_valid_reg;
        end
    end

    assign cv[0] = s1_valid_reg;
    assign ci[0] = s1_idx_reg;
    assign cs[0] = '0;
    assign cb[0] = s1_bits_reg;

    for (genvar c = 0; c < NCELL; c++)
    begin : g_cell
        gsc_cell #(
            .H     (H),
            .IW    (IW),
            .SW    (SW),
            .SLICE (c)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (cv[c]),
            .idx_in    (ci[c]),
            .sum_in    (cs[c]),
            .bits_in   (cb[c]),
            .valid_out (cv[c+1]),
            .idx_out   (ci[c+1]),
            .sum_out   (cs[c+1]),
            .bits_out  (cb[c+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            example_count_reg    <= CFG_DATA_W'(64);
            hypothesis_count_reg <= CFG_DATA_W'(64);
            used_reg             <= '0;
            hmask_reg            <= '0;
            covered_reg          <= H'(1) << (H - 1);
            first_reg            <= 1'b0;
            scan_idx_reg         <= '0;
            drain_reg            <= '0;
            best_gain_reg        <= '0;
            best_idx_reg         <= '0;
            best_bits_reg        <= '0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid)
            begin
                if (cfg_ch.index == REG_EXAMPLE_COUNT)
                begin
                    example_count_reg <= cfg_ch.data;
                end
                else
                begin
                    hypothesis_count_reg <= cfg_ch.data;
                end
            end

            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Strict comparison keeps the lowest index on ties.
            if (cv[NCELL] && cs[NCELL] > best_gain_reg)
            begin
                best_gain_reg <= cs[NCELL];
                best_idx_reg  <= ci[NCELL];
                best_bits_reg <= cb[NCELL];
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire && in_ch.kind == KIND_RUN)
                    begin
                        used_reg      <= UW'(used_c);
                        hmask_reg     <= hmask_c;
                        covered_reg   <= H'(1) << (hc - HCW'(1));
                        first_reg     <= 1'b1;
                        scan_idx_reg  <= '0;
                        best_gain_reg <= '0;
                        best_idx_reg  <= '0;
                        best_bits_reg <= '0;
                        state_reg     <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (UW'(scan_idx_reg) + UW'(1) == used_reg)
                    begin
                        drain_reg <= '0;
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + IW'(1);
                    end
                end
                ST_DRAIN:
                begin
                    if (drain_reg == DW'(NCELL + 2))
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        drain_reg <= drain_reg + DW'(1);
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        first_reg     <= 1'b0;
                        if (first_reg || best_gain_reg != '0)
                        begin
                            covered_reg <= new_cov;
                            if (new_cov == hmask_reg)
                            begin
                                state_reg <= ST_IDLE;
                            end
                            else
                            begin
                                scan_idx_reg  <= '0;
                                best_gain_reg <= '0;
                                best_idx_reg  <= '0;
                                best_bits_reg <= '0;
                                state_reg     <= ST_SCAN;
                            end
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT && out_free)
        begin
            if (first_reg || best_gain_reg != '0)
            begin
                out_example_reg <= EX_IDX_W'(best_idx_reg);
                out_last_reg    <= (new_cov == hmask_reg);
                out_status_reg  <= STATUS_OK;
            end
            else
            begin
                out_example_reg <= '0;
                out_last_reg    <= 1'b1;
                out_status_reg  <= STATUS_UNCOVERABLE;
            end
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.chosen_example = out_example_reg;
    assign out_ch.last_pick      = out_last_reg;
    assign out_ch.status         = out_status_reg;

endmodule
